[hw/rtl/csvfs_pkg.sv]
// csvfs_pkg: shared types and constants of the CSV record field splitter.
// Holds the channel payload structs, event codes, register indexes and defaults.
// No dependencies.
`default_nettype none

package csvfs_pkg;

    // Default sizes handed to the top level
    localparam int BYTES_PER_CHUNK_DEF  = 8;
    localparam int MAX_BUFFER_BYTES_DEF = 65536;

    // Fixed field widths
    localparam int CHUNK_W = 64;
    localparam int VCNT_W  = 4;
    localparam int FIELD_W = 17;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    // Byte codes
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    // Line-ending modes; any other code behaves as LF
    localparam logic [1:0] MODE_LF   = 2'd0;
    localparam logic [1:0] MODE_CR   = 2'd1;
    localparam logic [1:0] MODE_CRLF = 2'd2;

    // Register reset values
    localparam logic [7:0] DELIM_RST = 8'd44;
    localparam logic [1:0] MODE_RST  = MODE_LF;

    // Register indexes (taken from the word address)
    localparam logic REG_DELIMITER_CHAR   = 1'b0;
    localparam logic REG_LINE_ENDING_MODE = 1'b1;

    typedef enum logic [2:0] {
        EV_FIELD        = 3'd0,
        EV_FINAL_FIELD  = 3'd1,
        EV_EMPTY_RECORD = 3'd2,
        EV_EMPTY_TRIM   = 3'd3,
        EV_PARTIAL      = 3'd4,
        EV_EMPTY_BUFFER = 3'd5,
        EV_TOO_LONG     = 3'd6
    } event_kind_t;

    typedef struct packed {
        logic [CHUNK_W-1:0] chunk_bytes;
        logic [VCNT_W-1:0]  valid_bytes;
        logic               first_of_buffer;
        logic               last_of_buffer;
    } in_item_t;

    typedef struct packed {
        event_kind_t        event_kind;
        logic [FIELD_W-1:0] field_offset;
        logic [FIELD_W-1:0] field_length;
        logic               merge_previous;
        logic [FIELD_W-1:0] consumed_count;
        logic               last_event;
    } out_item_t;

    typedef struct packed {
        logic [7:0] delimiter_char;
        logic [1:0] line_ending_mode;
    } cfg_t;

    // What one lane finds in its byte
    typedef struct packed {
        logic nl;
        logic delim;
        logic cr;
        logic ovf;
    } lane_flags_t;

endpackage

`default_nettype wire

[hw/rtl/csvfs_lane.sv]
// csvfs_lane: classifies one byte of the chunk (line end, delimiter, CR, overflow).
// Depends on csvfs_pkg.
`default_nettype none

module csvfs_lane #(
    parameter int BYTES_PER_CHUNK  = csvfs_pkg::BYTES_PER_CHUNK_DEF,
    parameter int MAX_BUFFER_BYTES = csvfs_pkg::MAX_BUFFER_BYTES_DEF,
    parameter int LANE_INDEX       = 0
) (
    input  wire logic [7:0]                                        byte_in,
    input  wire csvfs_pkg::cfg_t                                   cfg,
    input  wire logic [$clog2(MAX_BUFFER_BYTES+BYTES_PER_CHUNK+1)-1:0] base_offset,
    output csvfs_pkg::lane_flags_t                                 flags
);

    localparam int OFF_W = $clog2(MAX_BUFFER_BYTES + BYTES_PER_CHUNK + 1);

    logic [7:0] nl_byte;
    logic       crlf;

    // Pick the line-end byte for the mode
    assign nl_byte = (cfg.line_ending_mode == csvfs_pkg::MODE_CR) ?
                     csvfs_pkg::CH_CR : csvfs_pkg::CH_LF;
    assign crlf    = (cfg.line_ending_mode == csvfs_pkg::MODE_CRLF);

    // Classify the byte; in crlf mode a CR is never a delimiter
    assign flags.nl    = (byte_in == nl_byte);
    assign flags.cr    = (byte_in == csvfs_pkg::CH_CR);
    assign flags.delim = (byte_in == cfg.delimiter_char) &&
                         !(crlf && (byte_in == csvfs_pkg::CH_CR));
    assign flags.ovf   = ((base_offset + OFF_W'(LANE_INDEX)) >= OFF_W'(MAX_BUFFER_BYTES));

endmodule

`default_nettype wire

[hw/rtl/csvfs_merge.sv]
// csvfs_merge: merges the lane findings into field events in byte order, one per cycle
// unless the output stalls. Holds the record state and the output register. Depends on csvfs_pkg.
`default_nettype none

module csvfs_merge #(
    parameter int BYTES_PER_CHUNK  = csvfs_pkg::BYTES_PER_CHUNK_DEF,
    parameter int MAX_BUFFER_BYTES = csvfs_pkg::MAX_BUFFER_BYTES_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire csvfs_pkg::cfg_t       cfg,
    input  wire logic                  s_valid,
    input  wire csvfs_pkg::in_item_t   s_data,
    output logic                       s_ready,
    input  wire csvfs_pkg::lane_flags_t lane_flags [BYTES_PER_CHUNK],
    output logic [$clog2(MAX_BUFFER_BYTES+BYTES_PER_CHUNK+1)-1:0] base_offset,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output csvfs_pkg::out_item_t       m_data
);

    localparam int OFF_W  = $clog2(MAX_BUFFER_BYTES + BYTES_PER_CHUNK + 1);
    localparam int LANE_W = (BYTES_PER_CHUNK > 1) ? $clog2(BYTES_PER_CHUNK) : 1;
    localparam int CNT_W  = $clog2(BYTES_PER_CHUNK + 1);
    localparam int FW     = csvfs_pkg::FIELD_W;

    // Chunk control and record state
    logic                       busy_reg, busy_next;
    logic [CNT_W-1:0]           vcnt_reg, vcnt_next;
    logic                       last_reg, last_next;
    logic [BYTES_PER_CHUNK-1:0] pend_reg, pend_next;
    logic [OFF_W-1:0]           base_reg, base_next;
    logic [OFF_W-1:0]           cfs_reg, cfs_next;
    logic                       prev_cr_reg, prev_cr_next;
    logic                       lse_reg, lse_next;
    logic                       nfy_reg, nfy_next;
    logic                       rinc_reg, rinc_next;
    logic                       crp_reg, crp_next;
    logic                       m_valid_reg, m_valid_next;
    csvfs_pkg::out_item_t       m_data_reg, m_data_next;

    logic [BYTES_PER_CHUNK-1:0] pending;
    logic [BYTES_PER_CHUNK:0]   cr_before;
    logic [LANE_W-1:0]          k;
    logic                       found;
    logic                       more;
    logic                       crlf;
    logic                       can_emit;
    logic                       emit;
    logic                       done;
    logic                       accept;
    logic                       merge;
    logic                       prev_cr_k;
    logic                       last_cr;
    logic [OFF_W-1:0]           pos;
    logic [OFF_W-1:0]           le;
    logic [OFF_W-1:0]           end_off;
    logic [CNT_W-1:0]           v_sat;
    csvfs_pkg::lane_flags_t     kf;

    assign crlf     = (cfg.line_ending_mode == csvfs_pkg::MODE_CRLF);
    assign can_emit = !m_valid_reg || m_ready;
    assign merge    = nfy_reg && rinc_reg;

    // Event lanes still to report, and CR flag ahead of each byte
    always_comb begin
        cr_before[0] = prev_cr_reg;
        for (int i = 0; i < BYTES_PER_CHUNK; i++) begin
            pending[i]     = pend_reg[i] && (CNT_W'(i) < vcnt_reg) && !lse_reg &&
                             (lane_flags[i].ovf || lane_flags[i].nl || lane_flags[i].delim);
            cr_before[i+1] = lane_flags[i].cr;
        end
    end

    // Find the lowest pending lane
    always_comb begin
        k = '0;
        for (int i = BYTES_PER_CHUNK - 1; i >= 0; i--) begin
            if (pending[i]) begin
                k = LANE_W'(i);
            end
        end
    end

    assign found     = |pending;
    assign more      = |(pending & ~(BYTES_PER_CHUNK'(1) << k));
    assign kf        = lane_flags[k];
    assign prev_cr_k = cr_before[CNT_W'(k)];
    assign last_cr   = cr_before[vcnt_reg];
    assign pos       = base_reg + OFF_W'(k);
    assign end_off   = base_reg + OFF_W'(vcnt_reg);
    assign le        = (crlf && prev_cr_k && (pos != '0)) ? (pos - OFF_W'(1)) : pos;
    assign v_sat     = (s_data.valid_bytes > csvfs_pkg::VCNT_W'(BYTES_PER_CHUNK)) ?
                       CNT_W'(BYTES_PER_CHUNK) : CNT_W'(s_data.valid_bytes);
    assign s_ready   = !busy_reg || done;
    assign accept    = s_valid && s_ready;

    // Step the current chunk: report one event or close the chunk
    always_comb begin
        busy_next    = busy_reg;
        vcnt_next    = vcnt_reg;
        last_next    = last_reg;
        pend_next    = pend_reg;
        base_next    = base_reg;
        cfs_next     = cfs_reg;
        prev_cr_next = prev_cr_reg;
        lse_next     = lse_reg;
        nfy_next     = nfy_reg;
        rinc_next    = rinc_reg;
        crp_next     = crp_reg;
        m_data_next  = m_data_reg;
        emit         = 1'b0;
        done         = 1'b0;

        if (busy_reg) begin
            if (found) begin
                if (can_emit) begin
                    emit                       = 1'b1;
                    pend_next[k]               = 1'b0;
                    m_data_next                = '0;
                    if (kf.ovf) begin
                        // Buffer overrun: final event, rest ignored
                        m_data_next.event_kind = csvfs_pkg::EV_TOO_LONG;
                        m_data_next.last_event = 1'b1;
                        lse_next               = 1'b1;
                        done                   = 1'b1;
                    end else if (kf.nl) begin
                        // Line end closes the record
                        m_data_next.consumed_count = FW'(pos + OFF_W'(1));
                        m_data_next.last_event     = 1'b1;
                        if (le == '0) begin
                            m_data_next.event_kind = (crlf && crp_reg) ?
                                csvfs_pkg::EV_EMPTY_TRIM : csvfs_pkg::EV_EMPTY_RECORD;
                        end else begin
                            m_data_next.event_kind     = csvfs_pkg::EV_FINAL_FIELD;
                            m_data_next.field_offset   = FW'(cfs_reg);
                            m_data_next.field_length   = FW'(le - cfs_reg);
                            m_data_next.merge_previous = merge;
                            nfy_next                   = 1'b0;
                        end
                        rinc_next = 1'b0;
                        crp_next  = 1'b0;
                        lse_next  = 1'b1;
                        base_next = pos + OFF_W'(1);
                        done      = 1'b1;
                    end else begin
                        // Delimiter closes a field
                        m_data_next.event_kind     = csvfs_pkg::EV_FIELD;
                        m_data_next.field_offset   = FW'(cfs_reg);
                        m_data_next.field_length   = FW'(pos - cfs_reg);
                        m_data_next.merge_previous = merge;
                        nfy_next                   = 1'b0;
                        cfs_next                   = pos + OFF_W'(1);
                        if (!more && !last_reg) begin
                            base_next    = end_off;
                            prev_cr_next = last_cr;
                            done         = 1'b1;
                        end
                    end
                end
            end else if (lse_reg) begin
                // Chunk after the line end: drop it
                done = 1'b1;
            end else if (last_reg) begin
                // Close the buffer without a line end
                if (can_emit) begin
                    emit         = 1'b1;
                    done         = 1'b1;
                    m_data_next  = '0;
                    m_data_next.last_event = 1'b1;
                    base_next    = end_off;
                    prev_cr_next = last_cr;
                    lse_next     = 1'b1;
                    if (end_off == '0) begin
                        m_data_next.event_kind = csvfs_pkg::EV_EMPTY_BUFFER;
                    end else begin
                        m_data_next.event_kind     = csvfs_pkg::EV_PARTIAL;
                        m_data_next.field_offset   = FW'(cfs_reg);
                        m_data_next.field_length   = FW'(end_off - cfs_reg);
                        m_data_next.merge_previous = merge;
                        m_data_next.consumed_count = FW'(end_off);
                        nfy_next                   = 1'b0;
                        rinc_next                  = 1'b1;
                        if (last_cr) begin
                            crp_next = 1'b1;
                        end
                    end
                end
            end else begin
                // Chunk with nothing to report: advance the offset
                base_next    = end_off;
                prev_cr_next = last_cr;
                done         = 1'b1;
            end
            if (done) begin
                busy_next = 1'b0;
            end
        end

        // Take the next chunk; a new buffer restarts the offsets
        if (accept) begin
            busy_next = 1'b1;
            vcnt_next = v_sat;
            last_next = s_data.last_of_buffer;
            pend_next = '1;
            if (s_data.first_of_buffer) begin
                base_next    = '0;
                cfs_next     = '0;
                prev_cr_next = 1'b0;
                lse_next     = 1'b0;
                nfy_next     = 1'b1;
            end
        end
    end

    // Output register: load on emit, drop on transfer
    assign m_valid_next = emit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            base_reg    <= '0;
            cfs_reg     <= '0;
            prev_cr_reg <= 1'b0;
            lse_reg     <= 1'b0;
            nfy_reg     <= 1'b1;
            rinc_reg    <= 1'b0;
            crp_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            base_reg    <= base_next;
            cfs_reg     <= cfs_next;
            prev_cr_reg <= prev_cr_next;
            lse_reg     <= lse_next;
            nfy_reg     <= nfy_next;
            rinc_reg    <= rinc_next;
            crp_reg     <= crp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        vcnt_reg   <= vcnt_next;
        last_reg   <= last_next;
        pend_reg   <= pend_next;
        m_data_reg <= m_data_next;
    end

    assign base_offset = base_reg;
    assign m_valid     = m_valid_reg;
    assign m_data      = m_data_reg;

    // Plain field events never close a buffer
    a_field_not_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_data_reg.event_kind == csvfs_pkg::EV_FIELD) |->
        !m_data_reg.last_event && (m_data_reg.consumed_count == '0))
        else $error("field event marked final or with consumed count");

    // Events without a field carry zero position and no merge
    a_no_field_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && ((m_data_reg.event_kind == csvfs_pkg::EV_EMPTY_RECORD) ||
                        (m_data_reg.event_kind == csvfs_pkg::EV_EMPTY_TRIM) ||
                        (m_data_reg.event_kind == csvfs_pkg::EV_EMPTY_BUFFER) ||
                        (m_data_reg.event_kind == csvfs_pkg::EV_TOO_LONG)) |->
        (m_data_reg.field_offset == '0) && (m_data_reg.field_length == '0) &&
        !m_data_reg.merge_previous)
        else $error("fieldless event with nonzero field data");

    // The chunk base never passes the buffer limit
    a_base_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        base_reg <= OFF_W'(MAX_BUFFER_BYTES))
        else $error("buffer offset beyond limit");

    // No event is issued once the buffer has ended
    a_silent_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && lse_reg |-> !emit)
        else $error("event issued after buffer end");

    // A completed record clears the incomplete and pending-CR marks
    a_record_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        emit && kf.nl && !kf.ovf && found |=> !rinc_reg && !crp_reg)
        else $error("record marks not cleared at line end");

endmodule

`default_nettype wire

[hw/rtl/csv_record_field_splitter_top.sv]
// csv_record_field_splitter_top: APB registers, chunk register, byte lanes and merge stage.
// Depends on csvfs_pkg, csvfs_lane and csvfs_merge.
//
//   channel | direction | handshake         | payload
//   --------+-----------+-------------------+-----------------------------
//   s_      | in        | s_valid / s_ready | in_item_t  (one chunk)
//   m_      | out       | m_valid / m_ready | out_item_t (one event)
//   apb     | in        | psel/penable      | delimiter, line-ending mode
//
// The merge stage reports one event per cycle while the output is not stalled,
// and holds the input until the chunk has yielded all its events (a closing
// partial-field event counts as one).
// Reset (aresetn low at a clock edge) clears the record state and the
// registers to delimiter 44 and LF mode. A stalled output holds the event
// in its register while the next event waits in the merge stage.
`default_nettype none

module csv_record_field_splitter_top #(
    parameter int BYTES_PER_CHUNK  = csvfs_pkg::BYTES_PER_CHUNK_DEF,
    parameter int MAX_BUFFER_BYTES = csvfs_pkg::MAX_BUFFER_BYTES_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [csvfs_pkg::ADDR_W-1:0]      paddr,
    input  wire logic [csvfs_pkg::DATA_W-1:0]      pwdata,
    output logic [csvfs_pkg::DATA_W-1:0]           prdata,
    output logic                                   pready,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire csvfs_pkg::in_item_t               s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output csvfs_pkg::out_item_t                   m_data
);

    localparam int OFF_W = $clog2(MAX_BUFFER_BYTES + BYTES_PER_CHUNK + 1);

    logic [7:0]                   delim_reg, delim_next;
    logic [1:0]                   mode_reg, mode_next;
    logic [csvfs_pkg::CHUNK_W-1:0] chunk_reg, chunk_next;
    logic                         cfg_write;
    csvfs_pkg::cfg_t              cfg;
    logic [OFF_W-1:0]             base_offset;
    csvfs_pkg::lane_flags_t       lane_flags [BYTES_PER_CHUNK];

    // Register port: write on access phase, read by word address
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        delim_next = delim_reg;
        mode_next  = mode_reg;
        if (cfg_write) begin
            case (paddr[2])
                csvfs_pkg::REG_DELIMITER_CHAR:   delim_next = pwdata[7:0];
                csvfs_pkg::REG_LINE_ENDING_MODE: mode_next  = pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            csvfs_pkg::REG_DELIMITER_CHAR:   prdata = {24'd0, delim_reg};
            csvfs_pkg::REG_LINE_ENDING_MODE: prdata = {30'd0, mode_reg};
            default:                         prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delim_reg <= csvfs_pkg::DELIM_RST;
            mode_reg  <= csvfs_pkg::MODE_RST;
        end else begin
            delim_reg <= delim_next;
            mode_reg  <= mode_next;
        end
    end

    assign cfg.delimiter_char   = delim_reg;
    assign cfg.line_ending_mode = mode_reg;

    // Hold the chunk bytes for the lanes while the merge stage works on it
    assign chunk_next = (s_valid && s_ready) ? s_data.chunk_bytes : chunk_reg;

    always_ff @(posedge aclk) begin
        chunk_reg <= chunk_next;
    end

    // One lane per byte of the chunk
    for (genvar g = 0; g < BYTES_PER_CHUNK; g++) begin : g_lane
        csvfs_lane #(
            .BYTES_PER_CHUNK  (BYTES_PER_CHUNK),
            .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES),
            .LANE_INDEX       (g)
        ) u_lane (
            .byte_in     (chunk_reg[8*g +: 8]),
            .cfg         (cfg),
            .base_offset (base_offset),
            .flags       (lane_flags[g])
        );
    end

    // Merge lane findings into events
    csvfs_merge #(
        .BYTES_PER_CHUNK  (BYTES_PER_CHUNK),
        .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES)
    ) u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .s_valid     (s_valid),
        .s_data      (s_data),
        .s_ready     (s_ready),
        .lane_flags  (lane_flags),
        .base_offset (base_offset),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

`default_nettype wire

[test/csv_record_field_splitter_top_test.sv]
`timescale 1ns / 100ps
// Testbench for csv_record_field_splitter_top: chunked text buffers in, field events out.
// Depends on csvfs_pkg and the splitter RTL; a scoreboard class predicts every event.

module csv_record_field_splitter_top_test;

    localparam int          PHASE_ITEMS   = 44;
    localparam int          IDLE_PCT      = 7;
    localparam int          SETTLE_CYCLES = 16;
    localparam int unsigned RUN_LIMIT     = 400000;

    // Register addresses: word index times four
    localparam logic [csvfs_pkg::ADDR_W-1:0] ADDR_DELIMITER =
        {csvfs_pkg::REG_DELIMITER_CHAR, 2'b00};
    localparam logic [csvfs_pkg::ADDR_W-1:0] ADDR_MODE =
        {csvfs_pkg::REG_LINE_ENDING_MODE, 2'b00};
    // Unused mode code, decoded as LF
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // Predicts the event stream of the splitter and checks what comes out
    class splitter_scoreboard;
        logic [7:0]           delim;
        logic [1:0]           mode;
        int unsigned          offset;
        int unsigned          field_start;
        bit                   prev_cr;
        bit                   line_done;
        bit                   no_field;
        bit                   rec_open;
        bit                   cr_wait;
        csvfs_pkg::out_item_t events_due[$];
        int                   errors;

        function new();
            delim       = csvfs_pkg::DELIM_RST;
            mode        = csvfs_pkg::MODE_RST;
            offset      = 0;
            field_start = 0;
            prev_cr     = 1'b0;
            line_done   = 1'b0;
            no_field    = 1'b1;
            rec_open    = 1'b0;
            cr_wait     = 1'b0;
            errors      = 0;
        endfunction

        function logic [7:0] eol_byte();
            return (mode == csvfs_pkg::MODE_CR) ? csvfs_pkg::CH_CR : csvfs_pkg::CH_LF;
        endfunction

        function int pending();
            return events_due.size();
        endfunction

        function void add_event(csvfs_pkg::event_kind_t kind, int unsigned off,
                                int unsigned len, bit mrg, int unsigned cons, bit fin);
            csvfs_pkg::out_item_t ev;
            ev.event_kind     = kind;
            ev.field_offset   = off[csvfs_pkg::FIELD_W-1:0];
            ev.field_length   = len[csvfs_pkg::FIELD_W-1:0];
            ev.merge_previous = mrg;
            ev.consumed_count = cons[csvfs_pkg::FIELD_W-1:0];
            ev.last_event     = fin;
            events_due.insert(events_due.size(), ev);
        endfunction

        // Scan one accepted chunk; returns 0 when the block ignores it
        function bit note_chunk(csvfs_pkg::in_item_t c);
            int unsigned count;
            int unsigned pos;
            int unsigned le;
            int          i;
            logic [7:0]  b;
            logic [7:0]  eol;
            bit          crlf;
            bit          mrg;
            count = (c.valid_bytes > csvfs_pkg::BYTES_PER_CHUNK_DEF) ?
                    csvfs_pkg::BYTES_PER_CHUNK_DEF : c.valid_bytes;
            crlf  = (mode == csvfs_pkg::MODE_CRLF);
            eol   = eol_byte();
            if (c.first_of_buffer) begin
                offset      = 0;
                field_start = 0;
                prev_cr     = 1'b0;
                line_done   = 1'b0;
                no_field    = 1'b1;
            end
            if (line_done)
                return 1'b0;

            for (i = 0; i < count; i++) begin
                b   = c.chunk_bytes[8*i +: 8];
                pos = offset;
                mrg = no_field && rec_open;
                // Byte past the size limit: abandon the buffer
                if (pos >= csvfs_pkg::MAX_BUFFER_BYTES_DEF) begin
                    add_event(csvfs_pkg::EV_TOO_LONG, 0, 0, 1'b0, 0, 1'b1);
                    line_done = 1'b1;
                    return 1'b1;
                end
                // Line end wins over the delimiter
                if (b == eol) begin
                    le = (crlf && prev_cr && pos > 0) ? pos - 1 : pos;
                    if (le == 0) begin
                        add_event((crlf && cr_wait) ? csvfs_pkg::EV_EMPTY_TRIM :
                                                      csvfs_pkg::EV_EMPTY_RECORD,
                                  0, 0, 1'b0, pos + 1, 1'b1);
                    end else begin
                        add_event(csvfs_pkg::EV_FINAL_FIELD, field_start,
                                  le - field_start, mrg, pos + 1, 1'b1);
                        no_field = 1'b0;
                    end
                    rec_open  = 1'b0;
                    cr_wait   = 1'b0;
                    line_done = 1'b1;
                    offset    = pos + 1;
                    return 1'b1;
                end
                // CR never splits fields in crlf mode
                if (b == delim && !(crlf && b == csvfs_pkg::CH_CR)) begin
                    add_event(csvfs_pkg::EV_FIELD, field_start, pos - field_start,
                              mrg, 0, 1'b0);
                    no_field    = 1'b0;
                    field_start = pos + 1;
                end
                prev_cr = (b == csvfs_pkg::CH_CR);
                offset  = pos + 1;
            end

            // Buffer closes without a line end
            if (c.last_of_buffer) begin
                if (offset == 0) begin
                    add_event(csvfs_pkg::EV_EMPTY_BUFFER, 0, 0, 1'b0, 0, 1'b1);
                end else begin
                    add_event(csvfs_pkg::EV_PARTIAL, field_start, offset - field_start,
                              no_field && rec_open, offset, 1'b1);
                    no_field = 1'b0;
                    rec_open = 1'b1;
                    if (prev_cr)
                        cr_wait = 1'b1;
                end
                line_done = 1'b1;
            end
            return 1'b1;
        endfunction

        function void compare_field(string name, logic [csvfs_pkg::FIELD_W-1:0] want,
                                    logic [csvfs_pkg::FIELD_W-1:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        // Compare one transfer on the result channel with the oldest prediction
        function void check_event(csvfs_pkg::out_item_t got);
            csvfs_pkg::out_item_t want;
            if (events_due.size() == 0) begin
                errors++;
                $display("%0t: expected no event, got kind %0d offset %0d length %0d",
                         $time, got.event_kind, got.field_offset, got.field_length);
                return;
            end
            want = events_due.pop_front();
            compare_field("event_kind", want.event_kind, got.event_kind);
            compare_field("field_offset", want.field_offset, got.field_offset);
            compare_field("field_length", want.field_length, got.field_length);
            compare_field("merge_previous", want.merge_previous, got.merge_previous);
            compare_field("consumed_count", want.consumed_count, got.consumed_count);
            compare_field("last_event", want.last_event, got.last_event);
        endfunction
    endclass

    logic                              aclk    = 1'b0;
    logic                              aresetn = 1'b0;
    logic                              psel    = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite  = 1'b0;
    logic [csvfs_pkg::ADDR_W-1:0]      paddr   = '0;
    logic [csvfs_pkg::DATA_W-1:0]      pwdata  = '0;
    logic [csvfs_pkg::DATA_W-1:0]      prdata;
    logic                              pready;
    logic                              s_valid = 1'b0;
    logic                              s_ready;
    csvfs_pkg::in_item_t               s_data  = '0;
    logic                              m_valid;
    logic                              m_ready = 1'b0;
    csvfs_pkg::out_item_t              m_data;

    splitter_scoreboard  sb;
    logic [7:0]          line_bytes[$];
    bit                  quiet       = 1'b0;
    int                  live_chunks = 0;
    int unsigned         cycle_count = 0;

    csv_record_field_splitter_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 0;
    end

    // Stall the result channel at random, except in the quiet stretch
    always @(posedge aclk) begin
        m_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Values at the falling edge are the ones sampled at the next rising edge
    always @(negedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_event(m_data);
    end

    // Guard against a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("csv_record_field_splitter_top_test: done, errors");
            $finish;
        end
    end

    // Append one byte to the text of the next buffer
    function automatic void add_byte(logic [7:0] b);
        line_bytes.insert(line_bytes.size(), b);
    endfunction

    // Hold one chunk until its transfer; called and left just after a rising edge
    task automatic send_chunk(csvfs_pkg::in_item_t item);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(negedge aclk);
        while (!s_ready)
            @(negedge aclk);
        if (sb.note_chunk(item))
            live_chunks++;
        @(posedge aclk);
    endtask

    // Single chunk from text; unused lanes carry junk
    task automatic send_text(string s, bit first, bit last, int vcount = -1);
        csvfs_pkg::in_item_t item;
        int                  k;
        item.chunk_bytes = {$urandom, $urandom};
        for (k = 0; k < s.len(); k++)
            item.chunk_bytes[8*k +: 8] = s[k];
        item.valid_bytes     = (vcount < 0) ? 4'(s.len()) : 4'(vcount);
        item.first_of_buffer = first;
        item.last_of_buffer  = last;
        send_chunk(item);
    endtask

    // Cut line_bytes into chunks of random size
    task automatic send_bytes(bit with_last);
        csvfs_pkg::in_item_t item;
        int unsigned         idx;
        int unsigned         take;
        int                  k;
        bit                  lead;
        bit                  done;
        idx  = 0;
        lead = 1'b1;
        done = 1'b0;
        while (!done) begin
            take = ($urandom_range(0, 99) < 5) ? 0 : $urandom_range(1, 8);
            if (take > line_bytes.size() - idx)
                take = line_bytes.size() - idx;
            item.chunk_bytes = {$urandom, $urandom};
            for (k = 0; k < take; k++)
                item.chunk_bytes[8*k +: 8] = line_bytes[idx + k];
            // Oversized counts saturate to a full chunk
            if (take == 8 && $urandom_range(0, 3) == 0)
                item.valid_bytes = 4'($urandom_range(9, 15));
            else
                item.valid_bytes = 4'(take);
            idx += take;
            done = (idx == line_bytes.size());
            item.first_of_buffer = lead;
            item.last_of_buffer  = with_last && done;
            lead = 1'b0;
            send_chunk(item);
        end
    endtask

    function automatic logic [7:0] pick_byte(bit allow_eol);
        logic [7:0] b;
        int         r;
        r = $urandom_range(0, 99);
        if (r < 14)
            b = sb.delim;
        else if (r < 22)
            b = csvfs_pkg::CH_CR;
        else if (r < 28)
            b = csvfs_pkg::CH_LF;
        else
            b = 8'($urandom);
        if (!allow_eol && b == sb.eol_byte())
            b = 8'h41;
        return b;
    endfunction

    // One buffer of a random shape, mostly well-formed records
    task automatic send_random_buffer();
        csvfs_pkg::in_item_t item;
        int                  shape;
        int                  n;
        bit                  crlf;
        crlf  = (sb.mode == csvfs_pkg::MODE_CRLF);
        shape = $urandom_range(0, 99);
        n     = ($urandom_range(0, 19) == 0) ? $urandom_range(21, 120) : $urandom_range(0, 20);
        line_bytes.delete();
        if (shape < 45) begin
            // complete record, then trailing bytes to be ignored
            repeat (n) add_byte(pick_byte(1'b0));
            if (crlf && $urandom_range(0, 1))
                add_byte(csvfs_pkg::CH_CR);
            add_byte(sb.eol_byte());
            repeat ($urandom_range(0, 6)) add_byte(pick_byte(1'b1));
            send_bytes(1'b1);
        end else if (shape < 70) begin
            // record left open at the buffer end
            repeat (n + 1) add_byte(pick_byte(1'b0));
            send_bytes(1'b1);
        end else if (shape < 78) begin
            // open record whose last byte is CR
            repeat (n % 8) add_byte(pick_byte(1'b0));
            add_byte(csvfs_pkg::CH_CR);
            send_bytes(1'b1);
        end else if (shape < 86) begin
            // line end at the very start
            if (crlf && $urandom_range(0, 1))
                add_byte(csvfs_pkg::CH_CR);
            add_byte(sb.eol_byte());
            repeat ($urandom_range(0, 6)) add_byte(pick_byte(1'b1));
            send_bytes(1'b1);
        end else if (shape < 90) begin
            send_bytes(1'b1);
        end else if (shape < 96) begin
            // noise: any flags, any count
            item.chunk_bytes     = {$urandom, $urandom};
            item.valid_bytes     = 4'($urandom_range(0, 15));
            item.first_of_buffer = 1'($urandom_range(0, 1));
            item.last_of_buffer  = 1'($urandom_range(0, 1));
            send_chunk(item);
        end else begin
            // buffer cut off by the next start of buffer
            repeat (n + 1) add_byte(pick_byte(1'b0));
            send_bytes(1'b0);
        end
    endtask

    // APB write: setup then access
    task automatic write_reg(logic [csvfs_pkg::ADDR_W-1:0] addr,
                             logic [csvfs_pkg::DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apply_setting(logic [7:0] delim, logic [1:0] mode);
        write_reg(ADDR_DELIMITER, {24'd0, delim});
        sb.delim = delim;
        write_reg(ADDR_MODE, {30'd0, mode});
        sb.mode = mode;
    endtask

    // Drop valid and hold off until every predicted event has come out
    task automatic wait_results();
        s_valid <= 1'b0;
        do
            @(posedge aclk);
        while (sb.pending() != 0);
    endtask

    task automatic settle();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic run_phase(logic [7:0] delim, logic [1:0] mode, bit hush);
        int start;
        apply_setting(delim, mode);
        quiet = hush;
        start = live_chunks;
        while (live_chunks - start < PHASE_ITEMS) begin
            send_random_buffer();
            if ($urandom_range(0, 39) == 0)
                wait_results();
        end
        quiet = 1'b0;
        settle();
    endtask

    initial begin
        sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: comma, LF
        send_text("", 1'b1, 1'b1);
        send_text(",,,,,,,,", 1'b1, 1'b1);
        send_text("a,b\nzz", 1'b1, 1'b1);
        send_text("\n", 1'b1, 1'b1);
        send_text("ab,cd", 1'b1, 1'b1);
        send_text("x,y\n", 1'b1, 1'b1);
        send_text("ab,cd", 1'b1, 1'b1);
        send_text("\n", 1'b1, 1'b1);
        send_text("abcdefgh", 1'b1, 1'b0, 15);
        send_text("", 1'b0, 1'b1);
        send_text("junk\n", 1'b0, 1'b1);
        send_text("q\nrest", 1'b1, 1'b0);
        send_text("more", 1'b0, 1'b1);
        send_text("ab", 1'b1, 1'b0);
        send_text(",c\n", 1'b0, 1'b1);
        settle();

        // CRLF: cut CR, trim after a pending CR
        apply_setting(8'd44, csvfs_pkg::MODE_CRLF);
        send_text("ab\r", 1'b1, 1'b1);
        send_text("\n", 1'b1, 1'b1);
        send_text("a\r\n", 1'b1, 1'b1);
        send_text("\r\n", 1'b1, 1'b1);
        send_text("a\r", 1'b1, 1'b1);
        send_text("\r\n", 1'b1, 1'b1);
        settle();

        run_phase(8'd0, csvfs_pkg::MODE_CR, 1'b0);
        run_phase(8'd255, csvfs_pkg::MODE_CRLF, 1'b0);
        run_phase(csvfs_pkg::CH_CR, csvfs_pkg::MODE_CRLF, 1'b1);
        run_phase(csvfs_pkg::CH_LF, csvfs_pkg::MODE_LF, 1'b0);
        run_phase(8'd59, MODE_SPARE, 1'b0);
        run_phase(8'd9, csvfs_pkg::MODE_CRLF, 1'b0);
        run_phase(csvfs_pkg::CH_CR, csvfs_pkg::MODE_CR, 1'b0);
        run_phase(8'd44, csvfs_pkg::MODE_LF, 1'b0);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("csv_record_field_splitter_top_test: done, clean");
        else
            $display("csv_record_field_splitter_top_test: done, errors");
        $finish;
    end

endmodule
